[hw/rtl/odqd_pkg.sv]
// ----------------------------------------------------------------------------
// odqd_pkg
// Types and op codes shared by the ordered deque cells, control and top level.
// ----------------------------------------------------------------------------
package odqd_pkg;

    // op codes carried in the input item
    localparam logic [2:0] OP_PREPEND = 3'd0;
    localparam logic [2:0] OP_APPEND  = 3'd1;
    localparam logic [2:0] OP_DEQUEUE = 3'd2;
    localparam logic [2:0] OP_PEEK    = 3'd3;
    localparam logic [2:0] OP_DELETE  = 3'd4;
    localparam logic [2:0] OP_ORDERED = 3'd5;

    // input item payload
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] item_value;
        logic [63:0] order_key;
    } t_in_item;

    // result item payload
    typedef struct packed {
        logic        status;
        logic [31:0] item_out;
        logic [4:0]  count;
    } t_out_item;

    // per-cell load selects
    typedef struct packed {
        logic take_new;
        logic take_left;
        logic take_right;
    } t_cell_ctl;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SRCH,
        ST_APPLY
    } t_state;

endpackage

[hw/rtl/odqd_cell.sv]
// ----------------------------------------------------------------------------
// odqd_cell
// One slot of the ordered row: holds a value and key, flags a local match
// for the current op and loads from the new item or either neighbor.
// ----------------------------------------------------------------------------
module odqd_cell (
    input  logic                 i_clk,
    input  odqd_pkg::t_in_item   i_cmd,
    input  logic                 i_valid,
    input  odqd_pkg::t_cell_ctl  i_ctl,
    input  logic [31:0]          i_left_value,
    input  logic [63:0]          i_left_key,
    input  logic [31:0]          i_right_value,
    input  logic [63:0]          i_right_key,
    output logic [31:0]          o_value,
    output logic [63:0]          o_key,
    output logic                 o_match
);
    import odqd_pkg::*;

    logic [31:0] r_value;
    logic [63:0] r_key;

    // local match: the op's position lies at or before this slot
    always_comb begin
        unique case (i_cmd.op) inside
            OP_PREPEND, OP_DEQUEUE: o_match = 1'b1;
            OP_APPEND:              o_match = ~i_valid;
            OP_ORDERED:             o_match = ~(i_valid && (i_cmd.order_key > r_key));
            OP_DELETE:              o_match = i_valid && (i_cmd.item_value == r_value);
            default:                o_match = 1'b0;
        endcase
    end

    // slot payload: new item, shift toward tail, or shift toward head
    always_ff @(posedge i_clk) begin
        if (i_ctl.take_new) begin
            r_value <= i_cmd.item_value;
            r_key   <= i_cmd.order_key;
        end else if (i_ctl.take_left) begin
            r_value <= i_left_value;
            r_key   <= i_left_key;
        end else if (i_ctl.take_right) begin
            r_value <= i_right_value;
            r_key   <= i_right_key;
        end
    end

    assign o_value = r_value;
    assign o_key   = r_key;

endmodule

[hw/rtl/odqd_ctrl.sv]
// ----------------------------------------------------------------------------
// odqd_ctrl
// Picks the first matching slot, decides success and the new count, and
// drives the load selects of every cell.
// ----------------------------------------------------------------------------
module odqd_ctrl #(
    parameter int CAPACITY = 16,
    parameter int CW       = $clog2(CAPACITY + 1)
) (
    input  logic                 i_en,
    input  odqd_pkg::t_in_item   i_cmd,
    input  logic [CW-1:0]        i_count,
    input  logic [CAPACITY-1:0]  i_match,
    output odqd_pkg::t_cell_ctl  o_ctl [CAPACITY],
    output logic                 o_ok,
    output logic [CW-1:0]        o_count_next
);
    import odqd_pkg::*;

    logic [CAPACITY-1:0] w_first;
    logic [CAPACITY-1:0] w_ge;
    logic                w_is_ins;
    logic                w_is_rem;
    logic                w_nz;
    logic                w_full;
    logic                w_empty;
    logic                w_found;

    // first set bit and the slots at or after it
    assign w_first = i_match & (~i_match + {{(CAPACITY-1){1'b0}}, 1'b1});
    assign w_ge    = ~(w_first - {{(CAPACITY-1){1'b0}}, 1'b1});

    assign w_nz    = |i_cmd.item_value;
    assign w_full  = (i_count == CW'(CAPACITY));
    assign w_empty = (i_count == '0);
    assign w_found = |i_match;

    // op class and success
    always_comb begin
        w_is_ins = 1'b0;
        w_is_rem = 1'b0;
        unique case (i_cmd.op) inside
            OP_PREPEND, OP_APPEND, OP_ORDERED: begin
                w_is_ins = 1'b1;
                o_ok     = w_nz && !w_full;
            end
            OP_DEQUEUE: begin
                w_is_rem = 1'b1;
                o_ok     = !w_empty;
            end
            OP_PEEK:   o_ok = !w_empty;
            OP_DELETE: begin
                w_is_rem = 1'b1;
                o_ok     = w_nz && w_found;
            end
            default:   o_ok = 1'b0;
        endcase
    end

    // count after the op
    always_comb begin
        if (o_ok && w_is_ins) begin
            o_count_next = i_count + CW'(1);
        end else if (o_ok && w_is_rem) begin
            o_count_next = i_count - CW'(1);
        end else begin
            o_count_next = i_count;
        end
    end

    // cell load selects
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            o_ctl[i].take_new   = i_en && o_ok && w_is_ins && w_first[i];
            o_ctl[i].take_left  = i_en && o_ok && w_is_ins && w_ge[i] && !w_first[i];
            o_ctl[i].take_right = i_en && o_ok && w_is_rem && w_ge[i];
        end
    end

endmodule

[hw/rtl/ordered_deque_with_delete.sv]
// ----------------------------------------------------------------------------
// ordered_deque_with_delete
// Fixed-capacity ordered deque with delete, built as a row of slot cells
// that shift toward head or tail under a shared first-match control.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | i_in_valid / o_in_ready | i_in_data  (t_in_item)
//  out     | output    | o_out_valid/i_out_ready | o_out_data (t_out_item)
//
//  An item passes through a transfer into the command register, a parallel
//  match in every cell, then first-match select and one shift of the row.
//  Reset (synchronous, active low) clears the count and the handshake state.
//  The result sits in an output register; a new item is taken while it
//  waits, and the shift step holds until that register is free.
// ----------------------------------------------------------------------------
module ordered_deque_with_delete #(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  odqd_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output odqd_pkg::t_out_item  o_out_data
);
    import odqd_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    t_state              r_state, n_state;
    t_in_item            r_cmd;
    logic [CW-1:0]       r_count;
    logic [CAPACITY-1:0] r_match;
    logic                r_out_valid;
    t_out_item           r_out;

    logic                w_accept;
    logic                w_apply;
    logic                w_ok;
    logic [CW-1:0]       w_count_next;
    logic [CAPACITY-1:0] w_match;
    logic [CAPACITY-1:0] w_valid;
    t_cell_ctl           w_ctl [CAPACITY];
    logic [31:0]         w_value [CAPACITY];
    logic [63:0]         w_key [CAPACITY];
    logic                w_head_op;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and strobes
    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        w_apply    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_state = ST_SRCH;
            end
            ST_SRCH:  n_state = ST_APPLY;
            ST_APPLY: begin
                if (!r_out_valid || i_out_ready) begin
                    w_apply = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    // command capture
    always_ff @(posedge i_clk) begin
        if (w_accept) r_cmd <= i_in_data;
    end

    // occupancy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_apply) begin
            r_count <= w_count_next;
        end
    end

    // slot valid flags derived from the count
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_valid[i] = (CW'(i) < r_count);
        end
    end

    // row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [31:0] w_lv, w_rv;
        logic [63:0] w_lk, w_rk;
        if (g == 0) begin : g_head
            assign w_lv = '0;
            assign w_lk = '0;
        end else begin : g_mid
            assign w_lv = w_value[g-1];
            assign w_lk = w_key[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_rv = '0;
            assign w_rk = '0;
        end else begin : g_body
            assign w_rv = w_value[g+1];
            assign w_rk = w_key[g+1];
        end
        odqd_cell u_cell (
            .i_clk         (i_clk),
            .i_cmd         (r_cmd),
            .i_valid       (w_valid[g]),
            .i_ctl         (w_ctl[g]),
            .i_left_value  (w_lv),
            .i_left_key    (w_lk),
            .i_right_value (w_rv),
            .i_right_key   (w_rk),
            .o_value       (w_value[g]),
            .o_key         (w_key[g]),
            .o_match       (w_match[g])
        );
    end

    // registered match vector
    always_ff @(posedge i_clk) begin
        if (r_state == ST_SRCH) r_match <= w_match;
    end

    odqd_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .i_en         (w_apply),
        .i_cmd        (r_cmd),
        .i_count      (r_count),
        .i_match      (r_match),
        .o_ctl        (w_ctl),
        .o_ok         (w_ok),
        .o_count_next (w_count_next)
    );

    assign w_head_op = (r_cmd.op == OP_DEQUEUE) || (r_cmd.op == OP_PEEK);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_apply) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_apply) begin
            r_out.status   <= ~w_ok;
            r_out.item_out <= (w_ok && w_head_op) ? w_value[0] : 32'd0;
            r_out.count    <= 5'(w_count_next);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hw/rtl/odqd_checker.sv]
// ----------------------------------------------------------------------------
// odqd_checker
// Port-level checks of the ordered deque, bound to the top level.
// ----------------------------------------------------------------------------
module odqd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input odqd_pkg::t_in_item   i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input odqd_pkg::t_out_item  o_out_data
);
    import odqd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a failure never reports an item
    a_fail_no_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |-> o_out_data.item_out == 32'd0)
        else $error("failed result carries an item");

    // one item at a time: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after a transfer");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // a waiting input item holds until its transfer
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input item changed while waiting");

endmodule

bind ordered_deque_with_delete odqd_checker u_odqd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
